// ----- rtl/core/rgbkc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbkc_pkg: shared types and constants of the RGB kernel convolution
// Beat payload types, register map and the divider cell beat.
// ----------------------------------------------------------------------------
package rgbkc_pkg;

  localparam int COEF_ROW_W = 60;
  localparam int NUM_ROWS   = 5;
  localparam int DVS_W      = 18;
  localparam int DIM_CFG_W  = 11;
  localparam int REM_W      = 26;
  localparam int QUO_W      = 8;
  localparam int NUM_CH     = 3;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_DIVISOR = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  typedef struct packed {
    logic       flush;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_t;

  typedef struct packed {
    logic       frame_last;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } res_t;

  // one beat moving through the divider chain
  typedef struct packed {
    logic                           valid;
    logic [NUM_CH-1:0]              zero;
    logic [NUM_CH-1:0]              sat;
    logic [NUM_CH-1:0][REM_W-1:0]   rem;
    logic [DVS_W-1:0]               dvs;
    logic [NUM_CH-1:0][QUO_W-1:0]   quo;
  } div_beat_t;

endpackage

// ----- rtl/core/rgbkc_stream_if.sv -----
// ----------------------------------------------------------------------------
// rgbkc_stream_if: valid/ready stream channel
// Carries one payload beat per handshake.
// ----------------------------------------------------------------------------
interface rgbkc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/rgbkc_ram.sv -----
// ----------------------------------------------------------------------------
// rgbkc_ram: single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module rgbkc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/core/rgbkc_div_cell.sv -----
// ----------------------------------------------------------------------------
// rgbkc_div_cell: one restoring division step
// Resolves quotient bit BIT for all channels and hands the beat on.
// ----------------------------------------------------------------------------
module rgbkc_div_cell import rgbkc_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_beat_t beat_i,
  output div_beat_t beat_o
);

  div_beat_t        nxt;
  logic [REM_W-1:0] trial;
  logic             valid_q;
  div_beat_t        data_q;

  // trial subtract of the shifted divisor
  always_comb begin
    nxt   = beat_i;
    trial = REM_W'(beat_i.dvs) << BIT;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (beat_i.rem[ch] >= trial) begin
        nxt.rem[ch]      = beat_i.rem[ch] - trial;
        nxt.quo[ch][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    beat_o       = data_q;
    beat_o.valid = valid_q;
  end

endmodule

// ----- rtl/core/rgb_kernel_convolution.sv -----
// ----------------------------------------------------------------------------
// rgb_kernel_convolution: normalized 2-D RGB convolution on a raster stream
// Line store in RAM, windowed multiply-accumulate, divider cell chain.
// ----------------------------------------------------------------------------
// Item without a result: accepted while idle, and the block stays idle.
// Item with a result: the window walk over the single line store port, then
//   the 8-cell divider chain; one item is in work at a time.
// Reset (async, active low) clears control and registers to their defaults;
//   the line store is not cleared, every read entry is written first.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution import rgbkc_pkg::*; #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int COEF_BITS   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbkc_stream_if.sink   pix_i,
  rgbkc_stream_if.source res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int HALF    = KERNEL_SIZE / 2;
  localparam int RING    = KERNEL_SIZE + 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int K_W     = 2 * DIM_W + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int RING_W  = $clog2(RING);
  localparam int DEPTH   = RING * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(KERNEL_SIZE);
  localparam int SP_W    = DIM_W + 2;
  localparam int SL_W    = RING_W + 2;
  localparam int PROD_W  = 9 + COEF_BITS;
  localparam int ACC_W   = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WAIT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  // -------------------------------------------------------------------------
  // configuration registers
  logic [COEF_ROW_W-1:0] coef_q [NUM_ROWS];
  logic [DVS_W-1:0]      divisor_q;
  logic [DIM_CFG_W-1:0]  width_q, height_q;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;
  logic                  geom_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];
  assign geom_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) coef_q[r] <= '0;
      divisor_q <= DVS_W'(16);
      width_q   <= DIM_CFG_W'(1024);
      height_q  <= DIM_CFG_W'(1024);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIVISOR: divisor_q <= pwdata[DVS_W-1:0];
        REG_WIDTH:   width_q   <= pwdata[DIM_CFG_W-1:0];
        REG_HEIGHT:  height_q  <= pwdata[DIM_CFG_W-1:0];
        default:     coef_q[cfg_idx] <= pwdata[COEF_ROW_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_DIVISOR: prdata = 64'(divisor_q);
      REG_WIDTH:   prdata = 64'(width_q);
      REG_HEIGHT:  prdata = 64'(height_q);
      default:     prdata = 64'(coef_q[cfg_idx]);
    endcase
  end

  // -------------------------------------------------------------------------
  // frame geometry
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [2*DIM_W-1:0] total;
  logic [K_W-1:0]     lag, p_rel;
  logic               emit, last, wr_pix;

  always_comb begin
    if (width_q == '0) w_eff = DIM_W'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = DIM_W'(width_q);
    if (height_q == '0) h_eff = DIM_W'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = DIM_W'(height_q);
  end

  assign total = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
  assign lag   = K_W'(HALF) * K_W'(w_eff) + K_W'(HALF);

  // -------------------------------------------------------------------------
  // position counters
  logic [K_W-1:0]    k_q;
  logic [DIM_W-1:0]  icol_q, ocol_q, orow_q;
  logic [RING_W-1:0] iring_q, oring_q;
  logic              acc_in;
  state_e            state_q;

  assign p_rel  = k_q - lag;
  assign emit   = (k_q >= lag) && (p_rel < K_W'(total));
  assign last   = (p_rel == K_W'(total) - K_W'(1));
  assign wr_pix = k_q < K_W'(total);

  assign pix_i.ready = (state_q == S_IDLE);
  assign acc_in      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0; icol_q <= '0; iring_q <= '0;
      ocol_q <= '0; orow_q <= '0; oring_q <= '0;
    end else if (geom_wr || (acc_in && emit && last)) begin
      k_q <= '0; icol_q <= '0; iring_q <= '0;
      ocol_q <= '0; orow_q <= '0; oring_q <= '0;
    end else if (acc_in) begin
      k_q <= k_q + K_W'(1);
      if (icol_q == w_eff - DIM_W'(1)) begin
        icol_q  <= '0;
        iring_q <= (iring_q == RING_W'(RING - 1)) ? '0 : iring_q + RING_W'(1);
      end else begin
        icol_q <= icol_q + DIM_W'(1);
      end
      if (emit) begin
        if (ocol_q == w_eff - DIM_W'(1)) begin
          ocol_q  <= '0;
          orow_q  <= orow_q + DIM_W'(1);
          oring_q <= (oring_q == RING_W'(RING - 1)) ? '0 : oring_q + RING_W'(1);
        end else begin
          ocol_q <= ocol_q + DIM_W'(1);
        end
      end
    end
  end

  // snapshot of the output position under work
  logic [DIM_W-1:0]  wrow_q, wcol_q;
  logic [RING_W-1:0] wring_q;
  logic              wlast_q;

  always_ff @(posedge clk_i) begin
    if (acc_in && emit) begin
      wrow_q  <= orow_q;
      wcol_q  <= ocol_q;
      wring_q <= oring_q;
      wlast_q <= last;
    end
  end

  // -------------------------------------------------------------------------
  // window walk address generation
  logic [IDX_W-1:0]       ri_q, cj_q;
  logic signed [SP_W-1:0] rr, cc;
  logic signed [SL_W-1:0] slot_t;
  logic [RING_W-1:0]      slot;
  logic                   in_win;
  logic [AW-1:0]          rd_addr, wr_addr, ram_addr;
  logic [COEF_BITS-1:0]   coef_sel;
  logic [23:0]            ram_rdata;

  always_comb begin
    rr = $signed({2'b00, wrow_q}) + $signed(SP_W'(ri_q)) - $signed(SP_W'(HALF));
    cc = $signed({2'b00, wcol_q}) + $signed(SP_W'(cj_q)) - $signed(SP_W'(HALF));
    in_win = !rr[SP_W-1] && (rr < $signed({2'b00, h_eff})) &&
             !cc[SP_W-1] && (cc < $signed({2'b00, w_eff}));
    slot_t = $signed(SL_W'(wring_q)) + $signed(SL_W'(ri_q)) - $signed(SL_W'(HALF));
    if (slot_t < 0) slot = RING_W'(slot_t + $signed(SL_W'(RING)));
    else if (slot_t >= $signed(SL_W'(RING))) slot = RING_W'(slot_t - $signed(SL_W'(RING)));
    else slot = RING_W'(slot_t);
    rd_addr  = AW'(slot) * AW'(MAX_WIDTH) + AW'(cc[COL_W-1:0]);
    wr_addr  = AW'(iring_q) * AW'(MAX_WIDTH) + AW'(icol_q);
    ram_addr = acc_in ? wr_addr : rd_addr;
    coef_sel = coef_q[3'(ri_q)][cj_q*COEF_BITS +: COEF_BITS];
  end

  rgbkc_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (acc_in && wr_pix),
    .addr_i  (ram_addr),
    .wdata_i ({pix_i.payload.blue_in, pix_i.payload.green_in, pix_i.payload.red_in}),
    .rdata_o (ram_rdata)
  );

  // -------------------------------------------------------------------------
  // multiply-accumulate pipeline
  logic                           s1_v_q, s2_v_q, s1_mask_q;
  logic signed [COEF_BITS-1:0]    s1_coef_q;
  logic signed [PROD_W-1:0]       prod_q [NUM_CH];
  logic signed [ACC_W-1:0]        acc_q  [NUM_CH];
  logic                           issue, start;

  assign issue = (state_q == S_MAC);
  assign start = acc_in && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mask_q <= in_win;
    s1_coef_q <= coef_sel;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (s1_mask_q) prod_q[ch] <= $signed({1'b0, ram_rdata[8*ch +: 8]}) * s1_coef_q;
      else prod_q[ch] <= '0;
      if (start) acc_q[ch] <= '0;
      else if (s2_v_q) acc_q[ch] <= acc_q[ch] + ACC_W'(prod_q[ch]);
    end
  end

  // -------------------------------------------------------------------------
  // divider launch: signs, magnitudes and saturation
  div_beat_t               chain [QUO_W+1];
  logic signed [DVS_W-1:0] d_eff;
  logic [DVS_W-1:0]        d_mag;
  logic                    d_neg;
  logic [ACC_W-1:0]        s_mag;

  always_comb begin
    d_eff = (divisor_q == '0) ? DVS_W'(16) : $signed(divisor_q);
    d_neg = d_eff[DVS_W-1];
    d_mag = d_neg ? DVS_W'(-d_eff) : DVS_W'(d_eff);
    chain[0]       = '0;
    chain[0].valid = (state_q == S_DRAIN) && !s1_v_q && !s2_v_q;
    chain[0].dvs   = d_mag;
    s_mag          = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s_mag = acc_q[ch][ACC_W-1] ? ACC_W'(-acc_q[ch]) : ACC_W'(acc_q[ch]);
      chain[0].rem[ch]  = REM_W'(s_mag);
      chain[0].zero[ch] = acc_q[ch][ACC_W-1] ^ d_neg;
      chain[0].sat[ch]  = (REM_W+1)'(s_mag) >= ((REM_W+1)'(d_mag) << QUO_W);
    end
  end

  // divider cell chain, one quotient bit per cell
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    rgbkc_div_cell #(
      .BIT (QUO_W - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end

  // -------------------------------------------------------------------------
  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ri_q    <= '0;
      cj_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          ri_q <= '0;
          cj_q <= '0;
          if (start) state_q <= S_MAC;
        end
        S_MAC: begin
          if (cj_q == IDX_W'(KERNEL_SIZE - 1)) begin
            cj_q <= '0;
            if (ri_q == IDX_W'(KERNEL_SIZE - 1)) state_q <= S_DRAIN;
            else ri_q <= ri_q + IDX_W'(1);
          end else begin
            cj_q <= cj_q + IDX_W'(1);
          end
        end
        S_DRAIN: if (chain[0].valid) state_q <= S_WAIT;
        S_WAIT:  if (chain[QUO_W].valid) state_q <= S_OUT;
        S_OUT:   if (!res_o.valid || res_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // result capture and output register
  res_t                       result_q, out_q;
  logic                       out_v_q;
  logic [NUM_CH-1:0][7:0]     chan;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (chain[QUO_W].zero[ch]) chan[ch] = 8'd0;
      else if (chain[QUO_W].sat[ch]) chan[ch] = 8'd255;
      else chan[ch] = chain[QUO_W].quo[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && chain[QUO_W].valid) begin
      result_q.red_out    <= chan[0];
      result_q.green_out  <= chan[1];
      result_q.blue_out   <= chan[2];
      result_q.frame_last <= wlast_q;
    end
    if (state_q == S_OUT && (!out_v_q || res_o.ready)) out_q <= result_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_v_q || res_o.ready)) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  assign res_o.valid   = out_v_q;
  assign res_o.payload = out_q;

  // -------------------------------------------------------------------------
  // assertions
  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[QUO_W].valid |-> state_q == S_WAIT)
    else $error("divider result outside wait state");

  a_no_result_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && !emit) |=> state_q == S_IDLE)
    else $error("item without result left idle");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && emit && last) |=> k_q == '0)
    else $error("frame position not restarted after last beat");

endmodule
